FILE: src/opwbd_pkg.sv
// Shared constants and types for the optical pulse-width bit decoder.
`default_nettype none
package opwbd_pkg;

	localparam int BUFFER_BYTES = 32;
	localparam int END_RUN      = 3;
	localparam int MAX_BITS     = BUFFER_BYTES * 8;
	localparam int BITS_W       = $clog2(MAX_BITS + 1);

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int TICK_W      = 16;
	localparam int NOM_W       = 12;
	localparam int MARGIN_W    = 10;
	localparam int DARK_W      = 2;

	localparam int BIT_COUNT_W  = 9;
	localparam int BYTE_INDEX_W = 5;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ONE_WIDTH     = 3'd0,
		REG_ZERO_WIDTH    = 3'd1,
		REG_END_WIDTH     = 3'd2,
		REG_WIDTH_MARGIN  = 3'd3,
		REG_TIMEOUT_TICKS = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_ONE       = 3'd1,
		EV_ZERO      = 3'd2,
		EV_DONE      = 3'd3,
		EV_RESTART   = 3'd4,
		EV_UNALIGNED = 3'd5
	} event_t;

	function automatic logic near_width(
		input logic [TICK_W-1:0]   len,
		input logic [NOM_W-1:0]    nominal,
		input logic [MARGIN_W-1:0] margin
	);
		logic [TICK_W-1:0] nom_ext;
		logic [TICK_W-1:0] diff;
		nom_ext = TICK_W'(nominal);
		diff = (len >= nom_ext) ? (len - nom_ext) : (nom_ext - len);
		return diff <= TICK_W'(margin);
	endfunction

endpackage
`default_nettype wire

FILE: src/optical_pulse_width_bit_decoder_core.sv
// Optical pulse-width bit decoder: classifies light pulses and packs bits into bytes.
// Each accepted sample is held in the input register, then registered into the result register.
// Throughput: one sample per cycle unless out_stall holds the result; an input register feeds one pass
// of decode logic into the result register, and the decoder state updates as the result register loads.
// Reset: arst_n asynchronously clears the decoder state, pipeline valids and the
// configuration registers to their defaults (40, 20, 80, 5, 1000).
`default_nettype none
module optical_pulse_width_bit_decoder_core
	import opwbd_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data,

	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic                     light,

	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [2:0]                    event_res,
	output logic [BIT_COUNT_W-1:0]        bit_count,
	output logic [BYTE_INDEX_W-1:0]       byte_index,
	output logic [7:0]                    byte_value,
	output logic                          indicator
);

	logic [NOM_W-1:0]    one_width_q;
	logic [NOM_W-1:0]    zero_width_q;
	logic [NOM_W-1:0]    end_width_q;
	logic [MARGIN_W-1:0] width_margin_q;
	logic [TICK_W-1:0]   timeout_ticks_q;

	logic                in_pulse_q;
	logic [DARK_W-1:0]   dark_run_q;
	logic [TICK_W-1:0]   tick_count_q;
	logic                wait_expired_q;
	logic [BITS_W-1:0]   bits_q;
	logic [7:0]          partial_q;
	logic                activity_q;

	logic                valid_s1;
	logic                light_s1;

	logic                valid_s2;
	event_t              event_s2;
	logic [BIT_COUNT_W-1:0]  bit_count_s2;
	logic [BYTE_INDEX_W-1:0] byte_index_s2;
	logic [7:0]          byte_value_s2;
	logic                indicator_s2;

	logic                out_ready;
	logic                advance_s1;
	logic                take_in;

	logic                in_pulse_n;
	logic [DARK_W-1:0]   dark_run_n;
	logic [TICK_W-1:0]   tick_count_n;
	logic [TICK_W-1:0]   tick_inc;
	logic                wait_expired_n;
	logic [BITS_W-1:0]   bits_n;
	logic [7:0]          partial_n;
	logic                activity_n;
	event_t              ev_n;
	logic                is_one;
	logic                is_zero;
	logic                is_end;
	logic                store;
	logic [2:0]          pos;

	assign out_ready  = !valid_s2 || !out_stall;
	assign advance_s1 = valid_s1 && out_ready;
	assign in_stall   = valid_s1 && !out_ready;
	assign take_in    = in_valid && !in_stall;

	assign tick_inc = (tick_count_q != {TICK_W{1'b1}}) ? tick_count_q + 1'b1 : tick_count_q;
	assign is_one   = near_width(tick_inc, one_width_q, width_margin_q);
	assign is_zero  = near_width(tick_inc, zero_width_q, width_margin_q);
	assign is_end   = near_width(tick_inc, end_width_q, width_margin_q);
	assign pos      = bits_q[2:0];

	always_comb begin
		in_pulse_n     = in_pulse_q;
		dark_run_n     = dark_run_q;
		tick_count_n   = tick_count_q;
		wait_expired_n = wait_expired_q;
		bits_n         = bits_q;
		partial_n      = partial_q;
		activity_n     = activity_q;
		ev_n           = EV_NONE;
		store          = 1'b0;
		if (!in_pulse_q) begin
			if (light_s1) begin
				in_pulse_n     = 1'b1;
				dark_run_n     = '0;
				tick_count_n   = TICK_W'(1);
				wait_expired_n = 1'b0;
			end else begin
				tick_count_n = tick_inc;
				if (tick_inc > timeout_ticks_q && !wait_expired_q) begin
					wait_expired_n = 1'b1;
					bits_n         = '0;
					partial_n      = '0;
					ev_n           = EV_RESTART;
				end
			end
		end else begin
			tick_count_n = tick_inc;
			if (light_s1) begin
				dark_run_n = '0;
			end else if (dark_run_q != {DARK_W{1'b1}}) begin
				dark_run_n = dark_run_q + 1'b1;
			end
			if (32'(dark_run_n) >= END_RUN) begin
				in_pulse_n     = 1'b0;
				dark_run_n     = '0;
				tick_count_n   = '0;
				wait_expired_n = 1'b0;
				if (is_one || is_zero) begin
					if (bits_q >= BITS_W'(MAX_BITS)) begin
						bits_n    = '0;
						partial_n = '0;
						ev_n      = EV_RESTART;
					end else begin
						store = 1'b1;
						ev_n  = is_one ? EV_ONE : EV_ZERO;
					end
				end else if (is_end) begin
					if (pos == 3'd0) begin
						bits_n = '0;
						ev_n   = EV_DONE;
					end else begin
						activity_n = !activity_q;
						ev_n       = EV_UNALIGNED;
					end
				end else begin
					bits_n    = '0;
					partial_n = '0;
					ev_n      = EV_RESTART;
				end
			end else if (tick_inc > timeout_ticks_q) begin
				in_pulse_n     = 1'b0;
				dark_run_n     = '0;
				tick_count_n   = '0;
				wait_expired_n = 1'b0;
				bits_n         = '0;
				partial_n      = '0;
				ev_n           = EV_RESTART;
			end
		end
		if (store) begin
			partial_n = (pos == 3'd0) ? 8'h00 : partial_q;
			if (is_one) begin
				partial_n[3'd7 - pos] = 1'b1;
			end
			bits_n     = bits_q + 1'b1;
			activity_n = !activity_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_width_q     <= NOM_W'(40);
			zero_width_q    <= NOM_W'(20);
			end_width_q     <= NOM_W'(80);
			width_margin_q  <= MARGIN_W'(5);
			timeout_ticks_q <= TICK_W'(1000);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ONE_WIDTH:     one_width_q     <= cfg_data[NOM_W-1:0];
				REG_ZERO_WIDTH:    zero_width_q    <= cfg_data[NOM_W-1:0];
				REG_END_WIDTH:     end_width_q     <= cfg_data[NOM_W-1:0];
				REG_WIDTH_MARGIN:  width_margin_q  <= cfg_data[MARGIN_W-1:0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			light_s1 <= light;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pulse_q     <= 1'b0;
			dark_run_q     <= '0;
			tick_count_q   <= '0;
			wait_expired_q <= 1'b0;
			bits_q         <= '0;
			partial_q      <= '0;
			activity_q     <= 1'b0;
			valid_s2       <= 1'b0;
		end else begin
			if (advance_s1) begin
				in_pulse_q     <= in_pulse_n;
				dark_run_q     <= dark_run_n;
				tick_count_q   <= tick_count_n;
				wait_expired_q <= wait_expired_n;
				bits_q         <= bits_n;
				partial_q      <= partial_n;
				activity_q     <= activity_n;
				valid_s2       <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			event_s2      <= ev_n;
			bit_count_s2  <= BIT_COUNT_W'(bits_n);
			byte_index_s2 <= (bits_n == '0) ? '0 : BYTE_INDEX_W'((bits_n - 1'b1) >> 3);
			byte_value_s2 <= (bits_n == '0) ? 8'h00 : partial_n;
			indicator_s2  <= activity_n;
		end
	end

	assign out_valid  = valid_s2;
	assign event_res  = event_s2;
	assign bit_count  = bit_count_s2;
	assign byte_index = byte_index_s2;
	assign byte_value = byte_value_s2;
	assign indicator  = indicator_s2;

	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	assert property (@(posedge clk) disable iff (!arst_n) bits_q <= BITS_W'(MAX_BITS))
		else $error("bit count beyond buffer size");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_DONE |-> bit_count == '0)
		else $error("completed message left bits behind");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bit_count == '0 |-> byte_index == '0 && byte_value == 8'h00)
		else $error("empty message reports a byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && (ev_n == EV_ONE || ev_n == EV_ZERO || ev_n == EV_UNALIGNED)
		|=> activity_q != $past(activity_q))
		else $error("indicator did not toggle on symbol");

endmodule
`default_nettype wire
